// ===== design/errs_pkg.sv =====
`default_nettype none

package errs_pkg;

    localparam int TIME_WIDTH_DEF     = 48;
    localparam int MEAN_FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TYPE   = CFG_IDX_W'(1);

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 32;

    typedef enum logic [1:0] {
        ST_ACCEPTED   = 2'd0,
        ST_WRONG_TYPE = 2'd1,
        ST_ID_RANGE   = 2'd2,
        ST_COMPLETE   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_STAT,
        S_DIFF,
        S_DIV,
        S_MEAN,
        S_MUL,
        S_TERM,
        S_SUM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

endpackage

`default_nettype wire

// ===== design/errs_div.sv =====
`default_nettype none

module errs_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire errs_pkg::t_div_req                 i_req,
    output logic                                    o_done,
    output logic [errs_pkg::DIVIDEND_W-1:0]         o_quotient
);

    localparam int NW = errs_pkg::DIVIDEND_W;
    localparam int DW = errs_pkg::DIVISOR_W;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_sub;
    logic          w_ge;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_quo;

    always_comb begin
        w_trial = {r_rem, r_quo[NW-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_sub   = w_trial - {1'b0, r_div};
        n_rem   = w_ge ? w_sub[DW-1:0] : w_trial[DW-1:0];
        n_quo   = {r_quo[NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== design/echo_reply_rtt_statistics.sv =====
`default_nettype none

// Echo reply RTT statistics. One reply enters per transfer on the s side and
// leaves one result on the m side. An accepted reply passes through the check,
// stat, diff, div, mean, mul, term and sum states before its result is loaded.
// The running mean divides by the reply count in a restoring divider at one
// quotient bit per cycle. The M2 term is built from four 32x32 partial
// products. A rejected or ignored reply goes from the check state straight to
// the done state. The s side is ready only between replies, from the cycle
// after the result is loaded, so a new reply is taken only once the last one
// is through. A finished result waits in the output register while the next
// reply is taken. A second finished result holds the block until the first
// one has left. Configuration writes are always ready and take effect
// at once.

module echo_reply_rtt_statistics #(
    parameter int TIME_WIDTH     = errs_pkg::TIME_WIDTH_DEF,
    parameter int MEAN_FRAC_BITS = errs_pkg::MEAN_FRAC_BITS_DEF,
    localparam int IN_BITS  = 64 + 2 * TIME_WIDTH,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 195 + 3 * TIME_WIDTH,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [errs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [errs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // msg_type, seq_id, sent_time_us, arrival_time_us
    input  wire logic [IN_W-1:0]                   i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // status, rtt_us, out_of_order, received_total, out_of_order_total,
    // rtt_min_us, rtt_max_us, rtt_mean_q16, rtt_m2
    output logic [OUT_W-1:0]                       o_m_tdata
);

    localparam int TW    = TIME_WIDTH;
    localparam int SHIFT = 2 * MEAN_FRAC_BITS;

    errs_pkg::t_state r_state;
    errs_pkg::t_state n_state;

    logic [31:0]    r_pkt_cnt;
    logic [31:0]    r_type_code;

    logic [31:0]    r_msg_type;
    logic [31:0]    r_seq_id;
    logic [TW-1:0]  r_sent;
    logic [TW-1:0]  r_arr;

    errs_pkg::t_status r_status;
    logic [TW-1:0]  r_rtt;
    logic           r_ooo;
    logic [31:0]    r_rcv_cnt;
    logic [31:0]    r_ooo_cnt;
    logic [31:0]    r_exp_id;
    logic [TW-1:0]  r_min;
    logic [TW-1:0]  r_max;
    logic [63:0]    r_mean;
    logic [63:0]    r_m2;

    logic [63:0]    r_x;
    logic [63:0]    r_d;
    logic           r_neg;
    logic [63:0]    r_e;
    logic [127:0]   r_acc;
    logic [63:0]    r_prod;
    logic [1:0]     r_prod_sh;
    logic [2:0]     r_mcnt;
    logic [63:0]    r_term;

    logic           r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    errs_pkg::t_status w_status;
    logic [TW-1:0]  w_rtt;
    logic [127:0]   w_x_wide;
    logic [63:0]    w_x;
    logic           w_neg;
    logic [63:0]    w_d;
    errs_pkg::t_div_req w_div_req;
    logic           w_div_done;
    logic [63:0]    w_quo;
    logic [31:0]    w_pa;
    logic [31:0]    w_pb;
    logic [63:0]    w_pp;
    logic [127:0]   w_pp_sh;
    logic [127:0]   w_acc_sh;
    logic [64:0]    w_m2_sum;
    logic           w_load;
    logic           w_accept;
    logic [OUT_W-1:0] w_out_data;

    always_comb begin
        if (r_rcv_cnt >= r_pkt_cnt) begin
            w_status = errs_pkg::ST_COMPLETE;
        end else if (r_msg_type != r_type_code) begin
            w_status = errs_pkg::ST_WRONG_TYPE;
        end else if (r_seq_id >= r_pkt_cnt) begin
            w_status = errs_pkg::ST_ID_RANGE;
        end else begin
            w_status = errs_pkg::ST_ACCEPTED;
        end

        w_rtt    = (r_arr >= r_sent) ? (r_arr - r_sent) : '0;
        w_x_wide = {64'd0, 64'(r_rtt)} << MEAN_FRAC_BITS;
        w_x      = (|w_x_wide[127:64]) ? '1 : w_x_wide[63:0];
        w_neg    = (r_x < r_mean);
        w_d      = w_neg ? (r_mean - r_x) : (r_x - r_mean);

        w_pa = r_mcnt[0] ? r_d[63:32] : r_d[31:0];
        w_pb = r_mcnt[1] ? r_e[63:32] : r_e[31:0];
        w_pp = {32'd0, w_pa} * {32'd0, w_pb};
        case (r_prod_sh)
            2'd0:    w_pp_sh = {64'd0, r_prod};
            2'd1:    w_pp_sh = {32'd0, r_prod, 32'd0};
            default: w_pp_sh = {r_prod, 64'd0};
        endcase

        w_acc_sh = r_acc >> SHIFT;
        w_m2_sum = {1'b0, r_m2} + {1'b0, r_term};

        w_div_req.start    = (r_state == errs_pkg::S_DIFF);
        w_div_req.dividend = w_d;
        w_div_req.divisor  = r_rcv_cnt;

        w_out_data = OUT_W'({r_m2, r_mean, r_max, r_min, r_ooo_cnt, r_rcv_cnt,
                             r_ooo, r_rtt, r_status});
    end

    errs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_accept = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state    = r_state;
        w_load     = 1'b0;
        o_s_tready = (r_state == errs_pkg::S_IDLE);
        case (r_state)
            errs_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = errs_pkg::S_CHECK;
                end
            end
            errs_pkg::S_CHECK: begin
                n_state = (w_status == errs_pkg::ST_ACCEPTED) ? errs_pkg::S_STAT
                                                              : errs_pkg::S_DONE;
            end
            errs_pkg::S_STAT: n_state = errs_pkg::S_DIFF;
            errs_pkg::S_DIFF: n_state = errs_pkg::S_DIV;
            errs_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = errs_pkg::S_MEAN;
                end
            end
            errs_pkg::S_MEAN: n_state = errs_pkg::S_MUL;
            errs_pkg::S_MUL: begin
                if (r_mcnt == 3'd4) begin
                    n_state = errs_pkg::S_TERM;
                end
            end
            errs_pkg::S_TERM: n_state = errs_pkg::S_SUM;
            errs_pkg::S_SUM:  n_state = errs_pkg::S_DONE;
            errs_pkg::S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    w_load  = 1'b1;
                    n_state = errs_pkg::S_IDLE;
                end
            end
            default: n_state = errs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= errs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_cnt   <= 32'd1;
            r_type_code <= 32'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == errs_pkg::CFG_PACKET_COUNT) begin
                r_pkt_cnt <= i_cfg_data;
            end else if (i_cfg_index == errs_pkg::CFG_REPLY_TYPE) begin
                r_type_code <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcv_cnt <= '0;
            r_ooo_cnt <= '0;
            r_exp_id  <= '0;
            r_min     <= '1;
            r_max     <= '0;
            r_mean    <= '0;
            r_m2      <= '0;
        end else begin
            case (r_state)
                errs_pkg::S_CHECK: begin
                    if (w_status == errs_pkg::ST_ACCEPTED) begin
                        r_rcv_cnt <= r_rcv_cnt + 32'd1;
                        if (r_seq_id < r_exp_id) begin
                            r_ooo_cnt <= r_ooo_cnt + 32'd1;
                        end else begin
                            r_exp_id <= r_seq_id + 32'd1;
                        end
                    end
                end
                errs_pkg::S_STAT: begin
                    if (r_rtt < r_min) begin
                        r_min <= r_rtt;
                    end
                    if (r_rtt > r_max) begin
                        r_max <= r_rtt;
                    end
                end
                errs_pkg::S_MEAN: begin
                    r_mean <= r_neg ? (r_mean - w_quo) : (r_mean + w_quo);
                end
                errs_pkg::S_SUM: begin
                    r_m2 <= w_m2_sum[64] ? '1 : w_m2_sum[63:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_msg_type <= i_s_tdata[31:0];
            r_seq_id   <= i_s_tdata[63:32];
            r_sent     <= i_s_tdata[64 +: TW];
            r_arr      <= i_s_tdata[64 + TW +: TW];
        end
        case (r_state)
            errs_pkg::S_CHECK: begin
                r_status <= w_status;
                if (w_status == errs_pkg::ST_ACCEPTED) begin
                    r_rtt <= w_rtt;
                    r_ooo <= (r_seq_id < r_exp_id);
                end else begin
                    r_rtt <= '0;
                    r_ooo <= 1'b0;
                end
            end
            errs_pkg::S_STAT: r_x <= w_x;
            errs_pkg::S_DIFF: begin
                r_d   <= w_d;
                r_neg <= w_neg;
            end
            errs_pkg::S_MEAN: begin
                r_e    <= r_d - w_quo;
                r_acc  <= '0;
                r_mcnt <= '0;
            end
            errs_pkg::S_MUL: begin
                if (r_mcnt != 3'd4) begin
                    r_prod    <= w_pp;
                    r_prod_sh <= {1'b0, r_mcnt[0]} + {1'b0, r_mcnt[1]};
                end
                if (r_mcnt != 3'd0) begin
                    r_acc <= r_acc + w_pp_sh;
                end
                r_mcnt <= r_mcnt + 3'd1;
            end
            errs_pkg::S_TERM: begin
                r_term <= (|w_acc_sh[127:64]) ? '1 : w_acc_sh[63:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_out_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
    import errs_pkg::*;

    localparam int TW = TIME_WIDTH_DEF;
    localparam int FB = MEAN_FRAC_BITS_DEF;
    localparam int IN_W  = ((64 + 2 * TW + 7) / 8) * 8;
    localparam int OUT_W = ((195 + 3 * TW + 7) / 8) * 8;

    localparam int OFF_RTT  = 2;
    localparam int OFF_OOO  = OFF_RTT + TW;
    localparam int OFF_RX   = OFF_OOO + 1;
    localparam int OFF_LATE = OFF_RX + 32;
    localparam int OFF_MIN  = OFF_LATE + 32;
    localparam int OFF_MAX  = OFF_MIN + TW;
    localparam int OFF_MEAN = OFF_MAX + TW;
    localparam int OFF_M2   = OFF_MEAN + 64;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = '1;

    localparam int LONG_HOLD   = 600;
    localparam int QUIET_LIMIT = 3000;

    typedef struct {
        logic [31:0]   msg_type;
        logic [31:0]   seq_id;
        logic [TW-1:0] sent_us;
        logic [TW-1:0] arrival_us;
    } echo_reply_t;

    typedef struct {
        t_status       status;
        logic [TW-1:0] rtt;
        logic          ooo;
        logic [31:0]   rx_total;
        logic [31:0]   late_total;
        logic [TW-1:0] min_us;
        logic [TW-1:0] max_us;
        logic [63:0]   mean;
        logic [63:0]   m2;
    } rtt_report_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_W-1:0]       i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_tdata;

    echo_reply_t pending_replies[$];
    rtt_report_t expected_reports[$];

    logic [31:0]   expect_replies = 32'd1;
    logic [31:0]   reply_code = 32'd1;
    logic [31:0]   rx_count = '0;
    logic [31:0]   late_count = '0;
    logic [31:0]   next_expected = '0;
    logic [TW-1:0] min_seen = '1;
    logic [TW-1:0] max_seen = '0;
    logic [63:0]   mean_q = '0;
    logic [63:0]   m2_acc = '0;

    int errors = 0;
    int idle_mode = 0;
    int holds_requested = 0;
    int holds_served = 0;
    int send_gap = 0;
    int sink_stall = 0;
    int quiet_cycles = 0;

    echo_reply_rtt_statistics DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic rtt_report_t score_reply(echo_reply_t r);
        rtt_report_t rep;
        logic [TW-1:0] rtt;
        logic [63:0] x, d, e, n;
        logic [127:0] prod;
        rep.status = ST_ACCEPTED;
        rep.rtt = '0;
        rep.ooo = 1'b0;
        if (rx_count >= expect_replies) begin
            rep.status = ST_COMPLETE;
        end else if (r.msg_type != reply_code) begin
            rep.status = ST_WRONG_TYPE;
        end else if (r.seq_id >= expect_replies) begin
            rep.status = ST_ID_RANGE;
        end else begin
            rx_count = rx_count + 1;
            rtt = (r.arrival_us >= r.sent_us) ? r.arrival_us - r.sent_us : '0;
            rep.rtt = rtt;
            rep.ooo = (r.seq_id < next_expected);
            if (rep.ooo) late_count = late_count + 1;
            if (rtt < min_seen) min_seen = rtt;
            if (rtt > max_seen) max_seen = rtt;
            x = ((64'(rtt) >> (64 - FB)) != 0) ? '1 : 64'(rtt) << FB;
            n = (rx_count == 0) ? 64'd1 : 64'(rx_count);
            if (x >= mean_q) begin
                d = x - mean_q;
                mean_q = mean_q + d / n;
                e = x - mean_q;
            end else begin
                d = mean_q - x;
                mean_q = mean_q - d / n;
                e = mean_q - x;
            end
            prod = (128'(d) * 128'(e)) >> (2 * FB);
            if (prod[127:64] != 0) prod = '1;
            m2_acc = (m2_acc > ~prod[63:0]) ? '1 : m2_acc + prod[63:0];
            if (r.seq_id >= next_expected) next_expected = r.seq_id + 1;
        end
        rep.rx_total = rx_count;
        rep.late_total = late_count;
        rep.min_us = min_seen;
        rep.max_us = max_seen;
        rep.mean = mean_q;
        rep.m2 = m2_acc;
        return rep;
    endfunction

    task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_report(logic [OUT_W-1:0] d);
        rtt_report_t want;
        if (expected_reports.size() == 0) begin
            $display("%0t unexpected result: expected none actual %h", $time, d);
            errors++;
        end else begin
            want = expected_reports.pop_front();
            cmp_field("status", 64'(want.status), 64'(d[1:0]));
            cmp_field("rtt_us", 64'(want.rtt), 64'(d[OFF_RTT +: TW]));
            cmp_field("out_of_order", 64'(want.ooo), 64'(d[OFF_OOO]));
            cmp_field("received_total", 64'(want.rx_total), 64'(d[OFF_RX +: 32]));
            cmp_field("out_of_order_total", 64'(want.late_total), 64'(d[OFF_LATE +: 32]));
            cmp_field("rtt_min_us", 64'(want.min_us), 64'(d[OFF_MIN +: TW]));
            cmp_field("rtt_max_us", 64'(want.max_us), 64'(d[OFF_MAX +: TW]));
            cmp_field("rtt_mean_q16", want.mean, d[OFF_MEAN +: 64]);
            cmp_field("rtt_m2", want.m2, d[OFF_M2 +: 64]);
        end
    endtask

    // sender: hold tvalid until transfer, then maybe idle for a burst
    always @(posedge i_clk) begin
        logic v;
        echo_reply_t head;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            v = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                head = pending_replies.pop_front();
                expected_reports.push_back(score_reply(head));
                v = 1'b0;
                if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 9 : 2) == 0)
                    send_gap = $urandom_range(1, 14);
            end
            if (!v) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_replies.size() != 0) begin
                    head = pending_replies[0];
                    i_s_tdata <= IN_W'({head.arrival_us, head.sent_us, head.seq_id,
                                        head.msg_type});
                    v = 1'b1;
                end
            end
            i_s_tvalid <= v;
        end
    end

    // receiver: check each transfer, stall in bursts or on a long hold request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) check_report(o_m_tdata);
            if (holds_served != holds_requested) begin
                holds_served++;
                sink_stall = LONG_HOLD;
            end
            if (sink_stall > 0) begin
                sink_stall--;
                i_m_tready <= 1'b0;
            end else if (idle_mode != 0 &&
                         $urandom_range(0, idle_mode == 1 ? 9 : 2) == 0) begin
                sink_stall = $urandom_range(0, 13);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    function automatic logic [TW-1:0] rand_time();
        return TW'({$urandom(), $urandom()});
    endfunction

    task automatic add_reply(logic [31:0] t, logic [31:0] id, logic [TW-1:0] sent,
                             logic [TW-1:0] arr);
        echo_reply_t r;
        r.msg_type = t;
        r.seq_id = id;
        r.sent_us = sent;
        r.arrival_us = arr;
        pending_replies.push_back(r);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PACKET_COUNT: expect_replies = val;
            CFG_REPLY_TYPE:   reply_code = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_replies.size() != 0 || expected_reports.size() != 0 || i_s_tvalid);
        repeat (4) @(negedge i_clk);
    endtask

    // one burst of mostly well-formed replies with some noise mixed in
    task automatic add_burst(int count, logic [31:0] t, logic [31:0] limit);
        logic [31:0] id, next_id, mt;
        logic [TW-1:0] sent, arr;
        int r;
        next_id = next_expected;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            mt = t;
            if (r < 10) begin
                mt = $urandom();
                if (mt == t) mt = ~mt;
                id = $urandom();
            end else if (r < 18) begin
                id = $urandom_range(32'hFFFF_FFFF, limit);
            end else if (r < 26 && next_id != 0) begin
                id = $urandom_range(next_id - 1, 0);
            end else if (r < 30) begin
                id = next_id + $urandom_range(1, 3);
                next_id = id + 1;
            end else begin
                id = next_id;
                next_id = next_id + 1;
            end
            sent = rand_time();
            case ($urandom_range(0, 9))
                0:       arr = rand_time();
                1:       arr = sent;
                default: arr = sent + TW'($urandom_range(0, 200000));
            endcase
            add_reply(mt, id, sent, arr);
        end
    endtask

    initial begin
        int made;
        int phase;
        int span;
        int burst_len;
        logic [31:0] base, t, limit;
        made = 0;
        phase = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // registers at reset values
        idle_mode = 1;
        add_reply(32'h0, 32'h0, 48'd10, 48'd20);
        add_reply(32'hFFFF_FFFF, 32'h0, 48'd10, 48'd20);
        add_reply(32'h1, 32'h1, 48'd10, 48'd20);
        add_reply(32'h1, 32'hFFFF_FFFF, 48'd10, 48'd20);
        add_reply(32'h1, 32'h0, 48'd1000, 48'd1250);
        add_reply(32'h1, 32'h0, 48'd1000, 48'd1100);
        drain();

        write_cfg(CFG_PACKET_COUNT, 32'h0);
        write_cfg(CFG_REPLY_TYPE, 32'h0);
        write_cfg(CFG_UNMAPPED, 32'h1234_5678);
        add_reply(32'h0, 32'h0, 48'd5, 48'd9);
        drain();

        write_cfg(CFG_PACKET_COUNT, 32'd12);
        add_reply(32'h0, 32'd3, 48'd500, 48'd480);
        add_reply(32'h0, 32'd4, '0, '0);
        add_reply(32'h0, 32'd2, 48'hFFFF_FFFF_FF00, '1);
        add_reply(32'h0, 32'd4, 48'd77, 48'd84);
        add_reply(32'h0, 32'd11, 48'd300, 48'd90300);
        add_reply(32'h0, 32'd12, 48'd300, 48'd400);
        add_reply(32'h0, 32'd5, '1, '0);
        add_reply(32'h1, 32'd6, 48'd10, 48'd70);
        add_reply(32'h0, 32'd6, 48'd10, 48'd70000);
        drain();

        while (made < 1000) begin
            idle_mode = $urandom_range(0, 2);
            case ($urandom_range(0, 5))
                0:       t = '0;
                1:       t = '1;
                default: t = $urandom();
            endcase
            base = (rx_count > next_expected) ? rx_count : next_expected;
            span = $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0)
                limit = rx_count >> 1;
            else
                limit = (base > 32'hFFFF_FFFF - span) ? '1 : base + span;
            write_cfg(CFG_REPLY_TYPE, t);
            write_cfg(CFG_PACKET_COUNT, limit);
            if (phase == 2) begin
                span = 40;
                idle_mode = 0;
                holds_requested++;
            end
            burst_len = span + span / 4 + $urandom_range(1, 4);
            add_burst(burst_len, t, limit);
            made += burst_len;
            phase++;
            drain();
        end

        // largest ids and RTT, then wide random content with no idling
        idle_mode = 1;
        t = $urandom();
        write_cfg(CFG_PACKET_COUNT, '1);
        write_cfg(CFG_REPLY_TYPE, t);
        add_reply(t, 32'hFFFF_FFFF, 48'd1, 48'd2);
        add_reply(t, 32'hFFFF_FFFE, '0, '1);
        add_reply(t, 32'h0, '1, '0);
        add_reply(t, 32'h7FFF_FFFF, 48'h8000_0000_0000, 48'hFFFF_0000_0000);
        drain();

        idle_mode = 0;
        for (int i = 0; i < 100; i++)
            add_reply(($urandom_range(0, 4) == 0) ? $urandom() : t, $urandom(),
                      rand_time(), rand_time());
        drain();

        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
